### src/bfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfg_pkg;

  localparam int MAX_COMPONENTS  = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int IDX_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_COMPONENTS + 1);
  // |offset| bound for an entry inside its radius: d*d <= radius_sq << F
  localparam int DMAG_W  = (32 + COORD_FRAC_BITS + 1) / 2;
  localparam int FQ_DEPTH = 2;
  localparam int INSIDE_TOL = 17;

  localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;
  localparam logic signed [49:0] SAT_MAX50 = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SAT_MIN50 = 50'sh3_8000_0000_0000;

  typedef enum logic {OP_LOAD = 1'b0, OP_EVAL = 1'b1} op_e;
  typedef enum logic [1:0] {
    KIND_SPHERE   = 2'd0,
    KIND_CYLINDER = 2'd1,
    KIND_BASE     = 2'd2,
    KIND_APEX     = 2'd3
  } kind_e;
  typedef enum logic {CFG_THRESHOLD = 1'b0, CFG_COUNT = 1'b1} cfg_idx_e;
  typedef enum logic {ST_IDLE = 1'b0, ST_EVAL = 1'b1} issue_state_e;

  // queued word, load fields already prepared by the front end
  typedef struct packed {
    op_e                op;
    logic [3:0]         index;
    kind_e              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        radius_sq;
    logic signed [32:0] z_top;     // z + length
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [32:0] oz_top;
    logic [30:0]        rsq;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } comp_t;

  typedef struct packed {
    logic v;
    logic first;
    logic last;
  } slot_ctl_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > SAT_MAX50) return SAT_MAX;
    if (v < SAT_MIN50) return SAT_MIN;
    return $signed(v[47:0]);
  endfunction

  // magnitude product -> shift (toward zero), apply sign, saturate
  function automatic logic signed [47:0] mulq_fin(input logic [79:0] m, input logic neg);
    logic [79:0] sh;
    sh = m >> COORD_FRAC_BITS;
    if (neg) begin
      if (sh > 80'h8000_0000_0000) return SAT_MIN;
      return -$signed(sh[47:0]);
    end
    if (sh > 80'h7FFF_FFFF_FFFF) return SAT_MAX;
    return $signed(sh[47:0]);
  endfunction

endpackage
`default_nettype wire

### src/blob_field_and_gradient_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | handshake                 | payload
// ----------+-----+---------------------------+-------------------------------------------
// input     | in  | in_valid_i / in_stall_o   | op, index, kind, x, y, z, radius_sq,
//           |     |                           | length, coef_quartic/quadratic/constant
// result    | out | out_valid_o / out_stall_i | density, inside_res, grad_x/y/z, grad_zero
// config    | in  | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// A load word passes through the component pipe's issue stage and gives no result.
// An evaluate word issues max(min(component_count, 16), 1) component slots, one per
// cycle while the result is not stalled, so back-to-back evaluations run at that rate;
// the result word follows the last slot through the accumulator into the output register.
// The issue stage and the component memory port set that rate.
// Reset clears control only; the component memory is undefined until loaded, no sweep.
// A stalled result freezes the whole component pipe; the two-word queue keeps taking
// input until it fills.
module blob_field_and_gradient_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [3:0]         index_i,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  input  wire logic [30:0]        radius_sq_i,
  input  wire logic [30:0]        length_i,
  input  wire logic signed [31:0] coef_quartic_i,
  input  wire logic signed [31:0] coef_quadratic_i,
  input  wire logic signed [31:0] coef_constant_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [47:0]      density_o,
  output logic                    inside_res_o,
  output logic signed [47:0]      grad_x_o,
  output logic signed [47:0]      grad_y_o,
  output logic signed [47:0]      grad_z_o,
  output logic                    grad_zero_o
);

  logic           q_valid, q_pop;
  bfg_pkg::item_t q_item;

  // front: accept, decode, prepare load fields, queue
  bfg_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .op_i, .index_i, .kind_i, .x_i, .y_i, .z_i, .radius_sq_i, .length_i,
    .coef_quartic_i, .coef_quadratic_i, .coef_constant_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: component memory, slot issue, arithmetic pipe, accumulators, result word
  bfg_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .density_o, .inside_res_o,
    .grad_x_o, .grad_y_o, .grad_z_o, .grad_zero_o
  );

endmodule
`default_nettype wire

### src/bfg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bfg_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [3:0]         index_i,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  input  wire logic [30:0]        radius_sq_i,
  input  wire logic [30:0]        length_i,
  input  wire logic signed [31:0] coef_quartic_i,
  input  wire logic signed [31:0] coef_quadratic_i,
  input  wire logic signed [31:0] coef_constant_i,
  output logic                    q_valid_o,
  output bfg_pkg::item_t          q_item_o,
  input  wire logic               q_pop_i
);

  localparam int PW = (bfg_pkg::FQ_DEPTH > 1) ? $clog2(bfg_pkg::FQ_DEPTH) : 1;
  localparam int CW = $clog2(bfg_pkg::FQ_DEPTH + 1);

  bfg_pkg::item_t fifo_q [bfg_pkg::FQ_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  bfg_pkg::item_t item;
  logic           acc, drop, push;

  assign in_stall_o = (cnt_q == CW'(bfg_pkg::FQ_DEPTH));
  assign acc        = in_valid_i && !in_stall_o;
  // loads aimed beyond the table are dropped here
  assign drop = (op_i == bfg_pkg::OP_LOAD) && (32'(index_i) >= bfg_pkg::MAX_COMPONENTS);
  assign push = acc && !drop;

  always_comb begin
    item.op        = bfg_pkg::op_e'(op_i);
    item.index     = index_i;
    item.kind      = bfg_pkg::kind_e'(kind_i);
    item.x         = x_i;
    item.y         = y_i;
    item.z         = z_i;
    item.radius_sq = radius_sq_i;
    item.z_top     = $signed({z_i[31], z_i}) + $signed({2'b00, length_i});
    item.coef_a    = coef_quartic_i;
    item.coef_b    = coef_quadratic_i;
    item.coef_c    = coef_constant_i;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (32'(wr_q) == bfg_pkg::FQ_DEPTH - 1) ? '0 : PW'(wr_q + 1'b1);
    end
    if (q_pop_i) begin
      rd_d = (32'(rd_q) == bfg_pkg::FQ_DEPTH - 1) ? '0 : PW'(rd_q + 1'b1);
    end
    if (push && !q_pop_i) cnt_d = CW'(cnt_q + 1'b1);
    else if (!push && q_pop_i) cnt_d = CW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= item;
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = fifo_q[rd_q];

endmodule
`default_nettype wire

### src/bfg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bfg_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               q_valid_i,
  input  wire bfg_pkg::item_t     q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [47:0]      density_o,
  output logic                    inside_res_o,
  output logic signed [47:0]      grad_x_o,
  output logic signed [47:0]      grad_y_o,
  output logic signed [47:0]      grad_z_o,
  output logic                    grad_zero_o
);

  localparam int F  = bfg_pkg::COORD_FRAC_BITS;
  localparam int DW = bfg_pkg::DMAG_W;
  localparam int NS = 13;   // stages 0..13 carry slot control

  function automatic logic [31:0] clamp_mag(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? $unsigned(-v) : $unsigned(v);
    if (m > 34'h0_8000_0000) return 32'h8000_0000;
    return m[31:0];
  endfunction

  // ---------------- config ----------------
  logic signed [31:0] threshold_q;
  logic [4:0]         count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 32'sd65536;
      count_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (bfg_pkg::cfg_idx_e'(cfg_index_i))
        bfg_pkg::CFG_THRESHOLD: threshold_q <= $signed(cfg_data_i);
        bfg_pkg::CFG_COUNT:     count_q     <= cfg_data_i[4:0];
      endcase
    end
  end

  // ---------------- issue ----------------
  logic                    out_valid_q;
  logic                    en;
  bfg_pkg::issue_state_e   st_q, st_d;
  logic [bfg_pkg::CNT_W-1:0] cnt_q, cnt_d, n_q, n_d, n_eval;
  logic [bfg_pkg::IDX_W-1:0] rd_idx;
  logic signed [31:0]      pt_x_q, pt_y_q, pt_z_q;
  bfg_pkg::slot_ctl_t      iss;
  logic                    iss_act, pop;

  assign en = !out_valid_q || !out_stall_i;
  assign n_eval = (32'(count_q) > bfg_pkg::MAX_COMPONENTS) ?
                  bfg_pkg::CNT_W'(bfg_pkg::MAX_COMPONENTS) : bfg_pkg::CNT_W'(count_q);

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    pop     = 1'b0;
    iss     = '0;
    iss_act = 1'b0;
    rd_idx  = cnt_q[bfg_pkg::IDX_W-1:0];
    unique case (st_q)
      bfg_pkg::ST_IDLE: begin
        if (en && q_valid_i) begin
          pop = 1'b1;
          if (q_item_i.op == bfg_pkg::OP_EVAL) begin
            // an empty table still runs one slot so the word gets a result
            iss.v     = 1'b1;
            iss.first = 1'b1;
            iss.last  = (n_eval <= bfg_pkg::CNT_W'(1));
            iss_act   = (n_eval != '0);
            rd_idx    = '0;
            if (n_eval > bfg_pkg::CNT_W'(1)) begin
              st_d  = bfg_pkg::ST_EVAL;
              cnt_d = bfg_pkg::CNT_W'(1);
              n_d   = n_eval;
            end
          end
        end
      end
      bfg_pkg::ST_EVAL: begin
        if (en) begin
          iss.v   = 1'b1;
          iss.last = (cnt_q == bfg_pkg::CNT_W'(n_q - 1'b1));
          iss_act = 1'b1;
          cnt_d   = bfg_pkg::CNT_W'(cnt_q + 1'b1);
          if (iss.last) st_d = bfg_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= bfg_pkg::ST_IDLE;
      cnt_q <= '0;
      n_q   <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      n_q   <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_item_i.op == bfg_pkg::OP_EVAL) begin
      pt_x_q <= q_item_i.x;
      pt_y_q <= q_item_i.y;
      pt_z_q <= q_item_i.z;
    end
  end

  // ---------------- component memory ----------------
  bfg_pkg::comp_t comp_mem [bfg_pkg::MAX_COMPONENTS];
  bfg_pkg::comp_t wr_ent;

  always_comb begin
    wr_ent.kind   = q_item_i.kind;
    wr_ent.ox     = q_item_i.x;
    wr_ent.oy     = q_item_i.y;
    wr_ent.oz     = q_item_i.z;
    wr_ent.oz_top = q_item_i.z_top;
    wr_ent.rsq    = q_item_i.radius_sq;
    wr_ent.a      = q_item_i.coef_a;
    wr_ent.b      = q_item_i.coef_b;
    wr_ent.c      = q_item_i.coef_c;
  end

  // ---------------- pipeline control ----------------
  bfg_pkg::slot_ctl_t ctl_q [NS+1];
  logic [NS:5]        hit_q;
  logic               act0_q, act1_q, act2_q, act3_q, act4_q;
  logic               zok1_q, zok2_q, zok3_q, zok4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) ctl_q[k] <= '0;
    end else if (en) begin
      ctl_q[0] <= iss;
      for (int k = 1; k <= NS; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // stage payloads
  bfg_pkg::comp_t     ent0_q;
  logic signed [31:0] px0_q, py0_q, pz0_q;
  logic signed [33:0] d1_q [3];
  logic [30:0]        rsq_q [1:4];
  logic signed [31:0] a_q [1:5];
  logic signed [31:0] b_q [1:7];
  logic signed [31:0] c_q [1:12];
  logic [31:0]        m2_q [3];
  logic [2:0]         sd_q [2:10];
  logic [DW-1:0]      dm_q [2:10][3];
  logic [63:0]        sq3_q [3];
  logic [63:0]        sum4_q;
  logic [31:0]        r2_q [5:10];
  logic [63:0]        pm6_q;
  logic               na6_q;
  logic signed [47:0] p7_q, q8_q, g8_q;
  logic [47:0]        qm9_q, gm9_q;
  logic               nq_q [9:11];
  logic               ng9_q;
  logic [55:0]        qlo10_q, qhi10_q;
  logic [DW+23:0]     glo10_q [3], ghi10_q [3];
  logic [2:0]         ngx_q [10:11];
  logic [79:0]        mq11_q;
  logic [79:0]        mg11_q [3];
  logic signed [47:0] mq12_q, t13_q;
  logic signed [47:0] g12_q [3], g13_q [3];

  // stage 1 combinational
  logic signed [32:0] dz0;
  logic signed [33:0] dzt;
  logic               zok1;
  logic signed [33:0] dz1;

  always_comb begin
    dz0 = $signed({pz0_q[31], pz0_q}) - $signed({ent0_q.oz[31], ent0_q.oz});
    dzt = $signed({{2{pz0_q[31]}}, pz0_q}) - $signed({ent0_q.oz_top[32], ent0_q.oz_top});
    zok1 = 1'b1;
    dz1  = $signed({dz0[32], dz0});
    unique case (ent0_q.kind)
      bfg_pkg::KIND_SPHERE: zok1 = 1'b1;
      bfg_pkg::KIND_CYLINDER: begin
        zok1 = !dz0[32] && (dzt[33] || dzt == '0);
        dz1  = '0;
      end
      bfg_pkg::KIND_BASE: zok1 = dz0[32] || dz0 == '0;
      bfg_pkg::KIND_APEX: begin
        zok1 = !dzt[33];
        dz1  = dzt;
      end
    endcase
  end

  // later stage combinational
  logic [31:0]        cm1 [3];
  logic [31:0]        amag6;
  logic signed [49:0] p50, b50;
  logic signed [49:0] c50, mq50;

  always_comb begin
    for (int k = 0; k < 3; k++) cm1[k] = clamp_mag(d1_q[k]);
  end

  assign amag6 = a_q[5][31] ? $unsigned(-a_q[5]) : $unsigned(a_q[5]);
  assign p50   = $signed({{2{p7_q[47]}}, p7_q});
  assign b50   = $signed({{18{b_q[7][31]}}, b_q[7]});
  assign c50   = $signed({{18{c_q[12][31]}}, c_q[12]});
  assign mq50  = $signed({{2{mq12_q[47]}}, mq12_q});

  always_ff @(posedge clk_i) begin
    if (pop && q_item_i.op == bfg_pkg::OP_LOAD) begin
      comp_mem[bfg_pkg::IDX_W'(q_item_i.index)] <= wr_ent;
    end
    if (en) begin
      // stage 0: registered table read
      ent0_q <= comp_mem[rd_idx];
      act0_q <= iss_act;
      px0_q  <= pop ? q_item_i.x : pt_x_q;
      py0_q  <= pop ? q_item_i.y : pt_y_q;
      pz0_q  <= pop ? q_item_i.z : pt_z_q;
      // stage 1: offsets and kind z test
      d1_q[0]  <= $signed({{2{px0_q[31]}}, px0_q}) - $signed({{2{ent0_q.ox[31]}}, ent0_q.ox});
      d1_q[1]  <= $signed({{2{py0_q[31]}}, py0_q}) - $signed({{2{ent0_q.oy[31]}}, ent0_q.oy});
      d1_q[2]  <= dz1;
      zok1_q   <= zok1;
      act1_q   <= act0_q;
      rsq_q[1] <= ent0_q.rsq;
      a_q[1]   <= ent0_q.a;
      b_q[1]   <= ent0_q.b;
      c_q[1]   <= ent0_q.c;
      // stage 2: clamped magnitudes
      for (int k = 0; k < 3; k++) begin
        m2_q[k]     <= cm1[k];
        sd_q[2][k]  <= d1_q[k][33];
        dm_q[2][k]  <= cm1[k][DW-1:0];
      end
      zok2_q <= zok1_q;
      act2_q <= act1_q;
      // stage 3: squares
      for (int k = 0; k < 3; k++) sq3_q[k] <= m2_q[k] * m2_q[k];
      zok3_q <= zok2_q;
      act3_q <= act2_q;
      // stage 4: squared distance
      sum4_q <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      zok4_q <= zok3_q;
      act4_q <= act3_q;
      // stage 5: truncated r2 (radius test sits in the hit register)
      r2_q[5]  <= sum4_q[F+31:F];
      // stage 6: r2 * a
      pm6_q <= r2_q[5] * amag6;
      na6_q <= a_q[5][31];
      // stage 7
      p7_q <= bfg_pkg::mulq_fin(80'(pm6_q), na6_q);
      // stage 8: q = p + b, g = -2p - b
      q8_q <= bfg_pkg::sat48(p50 + b50);
      g8_q <= bfg_pkg::sat48(-(p50 <<< 1) - b50);
      // stage 9: magnitudes
      qm9_q    <= q8_q[47] ? $unsigned(-q8_q) : $unsigned(q8_q);
      gm9_q    <= g8_q[47] ? $unsigned(-g8_q) : $unsigned(g8_q);
      nq_q[9]  <= q8_q[47];
      ng9_q    <= g8_q[47];
      // stage 10: split partial products
      qlo10_q <= r2_q[9] * qm9_q[23:0];
      qhi10_q <= r2_q[9] * qm9_q[47:24];
      for (int k = 0; k < 3; k++) begin
        glo10_q[k]    <= gm9_q[23:0] * dm_q[9][k];
        ghi10_q[k]    <= gm9_q[47:24] * dm_q[9][k];
        ngx_q[10][k]  <= ng9_q ^ sd_q[9][k];
      end
      nq_q[10] <= nq_q[9];
      // stage 11: recombine
      mq11_q <= 80'(qlo10_q) + (80'(qhi10_q) << 24);
      for (int k = 0; k < 3; k++) begin
        mg11_q[k] <= 80'(glo10_q[k]) + (80'(ghi10_q[k]) << 24);
      end
      nq_q[11]  <= nq_q[10];
      ngx_q[11] <= ngx_q[10];
      // stage 12: shift and saturate
      mq12_q <= bfg_pkg::mulq_fin(mq11_q, nq_q[11]);
      for (int k = 0; k < 3; k++) g12_q[k] <= bfg_pkg::mulq_fin(mg11_q[k], ngx_q[11][k]);
      // stage 13: density term
      t13_q <= bfg_pkg::sat48(mq50 + c50);
      g13_q <= g12_q;
      // shifting carries
      for (int s = 2; s <= 4; s++) rsq_q[s] <= rsq_q[s-1];
      for (int s = 2; s <= 5; s++) a_q[s] <= a_q[s-1];
      for (int s = 2; s <= 7; s++) b_q[s] <= b_q[s-1];
      for (int s = 2; s <= 12; s++) c_q[s] <= c_q[s-1];
      for (int s = 3; s <= 10; s++) begin
        sd_q[s] <= sd_q[s-1];
        dm_q[s] <= dm_q[s-1];
      end
      for (int s = 6; s <= 10; s++) r2_q[s] <= r2_q[s-1];
    end
  end

  // stage 5 radius test, then carried to the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else if (en) begin
      hit_q <= {hit_q[NS-1:5],
                act4_q && zok4_q && (sum4_q <= (64'(rsq_q[4]) << F))};
    end
  end

  // ---------------- accumulate (stage 14) ----------------
  logic signed [47:0] dens_q, gx_q, gy_q, gz_q;
  logic signed [47:0] dens_b, gx_b, gy_b, gz_b;
  logic               done_q;

  always_comb begin
    dens_b = ctl_q[13].first ? '0 : dens_q;
    gx_b   = ctl_q[13].first ? '0 : gx_q;
    gy_b   = ctl_q[13].first ? '0 : gy_q;
    gz_b   = ctl_q[13].first ? '0 : gz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en && ctl_q[13].v) begin
      if (hit_q[13]) begin
        dens_q <= bfg_pkg::sat48($signed({{2{dens_b[47]}}, dens_b}) +
                                 $signed({{2{t13_q[47]}}, t13_q}));
        gx_q <= bfg_pkg::sat48($signed({{2{gx_b[47]}}, gx_b}) +
                               $signed({{2{g13_q[0][47]}}, g13_q[0]}));
        gy_q <= bfg_pkg::sat48($signed({{2{gy_b[47]}}, gy_b}) +
                               $signed({{2{g13_q[1][47]}}, g13_q[1]}));
        gz_q <= bfg_pkg::sat48($signed({{2{gz_b[47]}}, gz_b}) +
                               $signed({{2{g13_q[2][47]}}, g13_q[2]}));
      end else begin
        dens_q <= dens_b;
        gx_q   <= gx_b;
        gy_q   <= gy_b;
        gz_q   <= gz_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else if (en) done_q <= ctl_q[13].v && ctl_q[13].last;
  end

  // ---------------- output register ----------------
  logic signed [47:0] thr;
  assign thr = $signed({{8{threshold_q[31]}}, threshold_q, 8'b0}) -
               48'(bfg_pkg::INSIDE_TOL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= done_q;
  end

  always_ff @(posedge clk_i) begin
    if (en && done_q) begin
      density_o    <= dens_q;
      inside_res_o <= dens_q > thr;
      grad_x_o     <= gx_q;
      grad_y_o     <= gy_q;
      grad_z_o     <= gz_q;
      grad_zero_o  <= (gx_q == '0) && (gy_q == '0) && (gz_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### src/bfg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bfg_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [47:0] density_o,
  input wire logic signed [47:0] grad_x_o,
  input wire logic signed [47:0] grad_y_o,
  input wire logic signed [47:0] grad_z_o,
  input wire logic               grad_zero_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(density_o) && $stable(grad_x_o))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> grad_zero_o == (grad_x_o == '0 && grad_y_o == '0 && grad_z_o == '0))
    else $error("grad_zero disagrees with gradient");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind blob_field_and_gradient_top bfg_checker u_bfg_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .density_o,
  .grad_x_o, .grad_y_o, .grad_z_o, .grad_zero_o
);
`default_nettype wire
